FILE: hdl/fem_pkg.sv
// shared types and constants for the flash envelope mixer
package fem_pkg;

  localparam int SLOTS_DEF = 8;
  localparam int CH_W      = 8;
  localparam int DUR_W     = 16;
  localparam int TMR_W     = 18;
  localparam int CNT_OUT_W = 4;
  localparam int DVD_W     = DUR_W + CH_W;
  localparam int QSTEPS    = CH_W;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef struct packed {
    logic             cmd;
    logic [CH_W-1:0]  red_in;
    logic [CH_W-1:0]  green_in;
    logic [CH_W-1:0]  blue_in;
    logic [CH_W-1:0]  alpha_in;
    logic [DUR_W-1:0] attack_ticks;
    logic [DUR_W-1:0] hold_ticks;
    logic [DUR_W-1:0] release_ticks;
    logic [DUR_W-1:0] frame_ticks;
  } fem_req_t;

  typedef struct packed {
    logic [CH_W-1:0]      mix_red;
    logic [CH_W-1:0]      mix_green;
    logic [CH_W-1:0]      mix_blue;
    logic [CH_W-1:0]      mix_alpha;
    logic [CNT_OUT_W-1:0] active_count;
    logic                 add_dropped;
  } fem_res_t;

  // one stored flash; colour[0] is red, colour[3] is alpha
  typedef struct packed {
    logic [TMR_W-1:0]      timer;
    logic [DUR_W-1:0]      rls;
    logic [DUR_W-1:0]      hld;
    logic [DUR_W-1:0]      atk;
    logic [3:0][CH_W-1:0]  colour;
  } fem_slot_t;

  typedef struct packed {
    logic capture;
    logic add_wr;
    logic rd_en;
    logic load;
    logic env;
    logic mul;
    logic step;
    logic acc;
    logic avg_load;
    logic avg_end;
    logic emit;
  } fem_cmd_t;

  typedef struct packed {
    logic live_cur;
    logic expired;
  } fem_sts_t;

endpackage

FILE: hdl/fem_ram.sv
// generic single write port ram with registered read
module fem_ram #(
  parameter int W = 8,
  parameter int D = 8
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                    wdata,
  input  logic                            re,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                    rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/fem_div.sv
// restoring divider, one quotient bit per step, quotient known to fit 8 bits
module fem_div
  import fem_pkg::*;
(
  input  logic             clk,
  input  logic             load,
  input  logic             step,
  input  logic [DVD_W-1:0] dvd,
  input  logic [DUR_W-1:0] den,
  output logic [CH_W-1:0]  quo
);

  logic [DUR_W-1:0] rem_r, rem_nxt;
  logic [CH_W-1:0]  low_r;
  logic [CH_W-1:0]  q_r;
  logic [DUR_W-1:0] den_r;
  logic [DUR_W:0]   trial;
  logic             qbit;

  always_comb begin
    trial = {rem_r, low_r[CH_W-1]};
    qbit  = (trial >= {1'b0, den_r});
    rem_nxt = qbit ? DUR_W'(trial - {1'b0, den_r}) : trial[DUR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem_r <= dvd[DVD_W-1:CH_W];
      low_r <= dvd[CH_W-1:0];
      den_r <= den;
      q_r   <= '0;
    end else if (step) begin
      rem_r <= rem_nxt;
      low_r <= {low_r[CH_W-2:0], 1'b0};
      q_r   <= {q_r[CH_W-2:0], qbit};
    end
  end

  assign quo = q_r;

endmodule

FILE: hdl/fem_datapath.sv
// slot store, envelope arithmetic, dividers and mix registers
module fem_datapath
  import fem_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  fem_req_t                                in_req,
  input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] idx,
  input  fem_cmd_t                                cmd,
  output fem_sts_t                                sts,
  output logic                                    out_valid,
  output fem_res_t                                out_res
);

  localparam int IDX_W = SLOTS > 1 ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int SUM_W = CH_W + CNT_W;

  fem_req_t              req_r;
  logic [SLOTS-1:0]      live_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  dropped_r;
  logic [3:0][CH_W-1:0]  mix_r;
  logic [TMR_W-1:0]      t_r;
  logic [DUR_W-1:0]      d1_r;
  logic [DUR_W:0]        d2_r;
  logic [TMR_W-1:0]      d3_r;
  logic [DUR_W-1:0]      rls_r;
  fem_slot_t             rec_r;
  logic [DUR_W-1:0]      num_r, num_nxt;
  logic [DUR_W-1:0]      den_r, den_nxt;
  logic [3:0][SUM_W-1:0] sum_r;
  fem_res_t              out_r;
  logic                  valid_r;

  logic [IDX_W-1:0]      free_idx;
  logic                  full;
  logic                  we;
  logic [IDX_W-1:0]      waddr;
  fem_slot_t             wdata, rdata, add_rec;
  logic [DUR_W:0]        d2_ld;
  logic [3:0][CH_W-1:0]  quo;
  logic [7:0]            cnt8;

  // lowest free slot
  always_comb begin
    free_idx = '0;
    full     = 1'b1;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!live_r[i]) begin
        free_idx = IDX_W'(i);
        full     = 1'b0;
      end
    end
  end

  always_comb begin
    add_rec.timer     = '0;
    add_rec.rls       = req_r.release_ticks;
    add_rec.hld       = req_r.hold_ticks;
    add_rec.atk       = req_r.attack_ticks;
    add_rec.colour[0] = req_r.red_in;
    add_rec.colour[1] = req_r.green_in;
    add_rec.colour[2] = req_r.blue_in;
    add_rec.colour[3] = req_r.alpha_in;
  end

  always_comb begin
    we    = (cmd.add_wr && !full) || cmd.env;
    waddr = cmd.add_wr ? free_idx : idx;
    wdata = rec_r;
    wdata.timer = t_r;
    if (cmd.add_wr) begin
      wdata = add_rec;
    end
  end

  fem_ram #(
    .W ($bits(fem_slot_t)),
    .D (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (idx),
    .rdata (rdata)
  );

  assign d2_ld = {1'b0, rdata.atk} + {1'b0, rdata.hld};

  // envelope fraction
  always_comb begin
    num_nxt = DUR_W'(1);
    den_nxt = DUR_W'(1);
    if (t_r <= TMR_W'(d1_r)) begin
      if (d1_r != '0) begin
        num_nxt = t_r[DUR_W-1:0];
        den_nxt = d1_r;
      end
    end else if (t_r <= TMR_W'(d2_r)) begin
      num_nxt = DUR_W'(1);
    end else if (rls_r == '0) begin
      num_nxt = '0;
    end else begin
      num_nxt = DUR_W'(d3_r - t_r);
      den_nxt = rls_r;
    end
  end

  assign sts.live_cur = live_r[idx];
  assign sts.expired  = (t_r >= d3_r);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_req;
    end
    if (cmd.load) begin
      t_r   <= TMR_W'(rdata.timer + TMR_W'(req_r.frame_ticks));
      d1_r  <= rdata.atk;
      d2_r  <= d2_ld;
      d3_r  <= TMR_W'(d2_ld) + TMR_W'(rdata.rls);
      rls_r <= rdata.rls;
      rec_r <= rdata;
    end
    if (cmd.env) begin
      num_r <= num_nxt;
      den_r <= den_nxt;
    end
  end

  genvar c;
  generate
    for (c = 0; c < 4; c++) begin : g_ch
      logic [DVD_W-1:0] dvd;
      logic [DUR_W-1:0] den;

      assign dvd = cmd.avg_load ? DVD_W'(sum_r[c]) : DVD_W'(rec_r.colour[c] * num_r);
      assign den = cmd.avg_load ? DUR_W'(cnt_r) : den_r;

      fem_div u_div (
        .clk  (clk),
        .load (cmd.mul || cmd.avg_load),
        .step (cmd.step),
        .dvd  (dvd),
        .den  (den),
        .quo  (quo[c])
      );

      always_ff @(posedge clk) begin
        if (cmd.capture) begin
          sum_r[c] <= '0;
        end else if (cmd.acc) begin
          sum_r[c] <= sum_r[c] + SUM_W'(quo[c]);
        end
      end
    end
  endgenerate

  assign cnt8 = 8'(cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r    <= '0;
      cnt_r     <= '0;
      mix_r     <= '0;
      dropped_r <= 1'b0;
      valid_r   <= 1'b0;
    end else begin
      valid_r <= cmd.emit;
      if (cmd.capture) begin
        dropped_r <= 1'b0;
      end
      if (cmd.add_wr) begin
        dropped_r <= full;
        if (!full) begin
          live_r[free_idx] <= 1'b1;
          cnt_r            <= cnt_r + CNT_W'(1);
        end
      end
      if (cmd.env && sts.expired) begin
        live_r[idx] <= 1'b0;
        cnt_r       <= cnt_r - CNT_W'(1);
      end
      if (cmd.avg_end) begin
        mix_r <= (cnt_r == '0) ? '0 : quo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.mix_red      <= mix_r[0];
      out_r.mix_green    <= mix_r[1];
      out_r.mix_blue     <= mix_r[2];
      out_r.mix_alpha    <= mix_r[3];
      out_r.active_count <= (cnt8 > 8'd15) ? 4'hF : cnt8[CNT_OUT_W-1:0];
      out_r.add_dropped  <= dropped_r;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = out_r;

endmodule

FILE: hdl/fem_ctrl.sv
// sequencer for add and tick requests
module fem_ctrl
  import fem_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  input  logic                                    req_cmd,
  input  fem_sts_t                                sts,
  output logic                                    busy,
  output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] idx,
  output fem_cmd_t                                cmd
);

  localparam int IDX_W = SLOTS > 1 ? $clog2(SLOTS) : 1;
  localparam int STP_W = $clog2(QSTEPS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_ADD, S_SCAN, S_LOAD, S_ENV, S_MUL, S_DIV, S_ACC,
    S_AVG_LOAD, S_AVG_DIV, S_AVG_END, S_DONE
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [STP_W-1:0] stp_r, stp_nxt;
  logic             last;

  assign last = (idx_r == LAST_IDX);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    stp_nxt   = stp_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          idx_nxt     = '0;
          state_nxt   = (req_cmd == CMD_ADD) ? S_ADD : S_SCAN;
        end
      end
      S_ADD: begin
        cmd.add_wr = 1'b1;
        state_nxt  = S_DONE;
      end
      S_SCAN: begin
        if (sts.live_cur) begin
          cmd.rd_en = 1'b1;
          state_nxt = S_LOAD;
        end else if (last) begin
          state_nxt = S_AVG_LOAD;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = S_ENV;
      end
      S_ENV: begin
        cmd.env = 1'b1;
        if (!sts.expired) begin
          state_nxt = S_MUL;
        end else if (last) begin
          state_nxt = S_AVG_LOAD;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = S_SCAN;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        stp_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.step = 1'b1;
        stp_nxt  = stp_r + STP_W'(1);
        if (stp_r == STP_W'(QSTEPS - 1)) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (last) begin
          state_nxt = S_AVG_LOAD;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = S_SCAN;
        end
      end
      S_AVG_LOAD: begin
        cmd.avg_load = 1'b1;
        stp_nxt      = '0;
        state_nxt    = S_AVG_DIV;
      end
      S_AVG_DIV: begin
        cmd.step = 1'b1;
        stp_nxt  = stp_r + STP_W'(1);
        if (stp_r == STP_W'(QSTEPS - 1)) begin
          state_nxt = S_AVG_END;
        end
      end
      S_AVG_END: begin
        cmd.avg_end = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      stp_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      stp_r   <= stp_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);
  assign idx  = idx_r;

endmodule

FILE: hdl/flash_envelope_mixer_top.sv
// top level of the flash envelope mixer: controller plus datapath
//
// usage
//   a request is taken on a rising edge with start high and busy low; in_req
//   carries the command bit and the add or tick fields
//   an add request stores the flash in the lowest free slot, or flags
//   add_dropped when every slot is live
//   a tick request walks the slots one at a time, advancing each live timer,
//   freeing finished flashes and scaling each colour by the envelope, then
//   averages the scaled colours over the flashes still live
//   exactly one result per request: out_valid is high for one cycle with the
//   result on out_res; the receiver cannot stall, so nothing waits
//   the four colour channels are divided side by side by 8 step serial
//   dividers, one quotient bit per cycle
//   busy stays high until the result register is loaded
//   reset (synchronous, active low) frees every slot and clears the mix;
//   slot contents are left as they are and are only read for live slots
module flash_envelope_mixer_top
  import fem_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  fem_req_t in_req,
  output logic     out_valid,
  output fem_res_t out_res
);

  localparam int IDX_W = SLOTS > 1 ? $clog2(SLOTS) : 1;

  // command and status between sequencer and datapath
  fem_cmd_t         cmd;
  fem_sts_t         sts;
  logic [IDX_W-1:0] idx;

  fem_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .req_cmd (in_req.cmd),
    .sts     (sts),
    .busy    (busy),
    .idx     (idx),
    .cmd     (cmd)
  );

  fem_datapath #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .idx       (idx),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule

FILE: verif/flash_envelope_mixer_checker.sv
// mix predictor and result checker for the flash envelope mixer
module flash_envelope_mixer_checker
  import fem_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     busy,
  input  fem_req_t in_req,
  input  logic     out_valid,
  input  fem_res_t out_res,
  output int       fail_count,
  output int       pending_mixes
);

  logic [3:0][7:0] flash_rgba [SLOTS];
  logic [15:0]     flash_atk [SLOTS];
  logic [15:0]     flash_hld [SLOTS];
  logic [15:0]     flash_rls [SLOTS];
  logic [17:0]     flash_tmr [SLOTS];
  logic            flash_live [SLOTS];
  logic [3:0][7:0] cur_mix;
  fem_res_t        expected_mixes [$];

  function automatic fem_res_t predict_mix(fem_req_t r);
    fem_res_t    res;
    logic [31:0] d1, d2, d3, t, num, den, n, live_n;
    logic [31:0] sum [4];
    logic        placed;
    res = '0;
    placed = 1'b0;
    if (r.cmd == CMD_ADD) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (!placed && !flash_live[i]) begin
          flash_rgba[i] = {r.alpha_in, r.blue_in, r.green_in, r.red_in};
          flash_atk[i] = r.attack_ticks;
          flash_hld[i] = r.hold_ticks;
          flash_rls[i] = r.release_ticks;
          flash_tmr[i] = '0;
          flash_live[i] = 1'b1;
          placed = 1'b1;
        end
      end
      res.add_dropped = !placed;
    end else begin
      for (int c = 0; c < 4; c++) sum[c] = 0;
      n = 0;
      for (int i = 0; i < SLOTS; i++) begin
        if (flash_live[i]) begin
          d1 = flash_atk[i];
          d2 = d1 + flash_hld[i];
          d3 = d2 + flash_rls[i];
          t = (flash_tmr[i] + r.frame_ticks) & 32'h3FFFF;
          flash_tmr[i] = t[17:0];
          if (t >= d3) begin
            flash_live[i] = 1'b0;
          end else begin
            if (t <= d1) begin
              num = (d1 != 0) ? t : 1;
              den = (d1 != 0) ? d1 : 1;
            end else if (t <= d2) begin
              num = 1;
              den = 1;
            end else begin
              num = d3 - t;
              den = flash_rls[i];
            end
            for (int c = 0; c < 4; c++)
              sum[c] += 32'((64'(flash_rgba[i][c]) * num) / den);
            n++;
          end
        end
      end
      cur_mix = '0;
      if (n > 0)
        for (int c = 0; c < 4; c++)
          cur_mix[c] = (sum[c] / n > 255) ? 8'd255 : 8'(sum[c] / n);
    end
    live_n = 0;
    for (int i = 0; i < SLOTS; i++) live_n += flash_live[i];
    res.active_count = (live_n > 15) ? 4'd15 : live_n[3:0];
    res.mix_red = cur_mix[0];
    res.mix_green = cur_mix[1];
    res.mix_blue = cur_mix[2];
    res.mix_alpha = cur_mix[3];
    return res;
  endfunction

  always @(posedge clk) begin
    fem_res_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) flash_live[i] = 1'b0;
      cur_mix = '0;
      expected_mixes.delete();
      fail_count <= 0;
      pending_mixes <= 0;
    end else begin
      if (out_valid) begin
        if (expected_mixes.size() == 0) begin
          $error("result with no request outstanding");
          fail_count <= fail_count + 1;
        end else begin
          want = expected_mixes.pop_front();
          if (out_res.mix_red !== want.mix_red) begin
            $error("mix_red exp %0d got %0d", want.mix_red, out_res.mix_red);
            fail_count <= fail_count + 1;
          end
          if (out_res.mix_green !== want.mix_green) begin
            $error("mix_green exp %0d got %0d", want.mix_green, out_res.mix_green);
            fail_count <= fail_count + 1;
          end
          if (out_res.mix_blue !== want.mix_blue) begin
            $error("mix_blue exp %0d got %0d", want.mix_blue, out_res.mix_blue);
            fail_count <= fail_count + 1;
          end
          if (out_res.mix_alpha !== want.mix_alpha) begin
            $error("mix_alpha exp %0d got %0d", want.mix_alpha, out_res.mix_alpha);
            fail_count <= fail_count + 1;
          end
          if (out_res.active_count !== want.active_count) begin
            $error("active_count exp %0d got %0d", want.active_count,
                   out_res.active_count);
            fail_count <= fail_count + 1;
          end
          if (out_res.add_dropped !== want.add_dropped) begin
            $error("add_dropped exp %0d got %0d", want.add_dropped,
                   out_res.add_dropped);
            fail_count <= fail_count + 1;
          end
        end
      end
      // predictor state is updated in place, ahead of any later request
      if (start && !busy) expected_mixes = {expected_mixes, predict_mix(in_req)};
      pending_mixes <= expected_mixes.size();
    end
  end

endmodule

FILE: verif/flash_envelope_mixer_top_tb.sv
// stimulus and verdict for the flash envelope mixer testbench
module flash_envelope_mixer_top_tb;
  import fem_pkg::*;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  fem_req_t in_req;
  logic     out_valid;
  fem_res_t out_res;
  int       fail_count;
  int       pending_mixes;

  flash_envelope_mixer_top DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req(in_req), .out_valid(out_valid), .out_res(out_res)
  );

  flash_envelope_mixer_checker checker_i (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_res(out_res), .fail_count(fail_count),
    .pending_mixes(pending_mixes)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // short random durations keep flashes cycling through every phase
  function automatic logic [15:0] pick_dur();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(1, 12));
    endcase
  endfunction

  function automatic fem_req_t make_add(logic [31:0] rgba, logic [15:0] a,
                                        logic [15:0] h, logic [15:0] r);
    fem_req_t     q;
    logic [127:0] rnd;
    rnd = {$urandom, $urandom, $urandom, $urandom};
    q = rnd[$bits(fem_req_t)-1:0];
    q.cmd = CMD_ADD;
    {q.alpha_in, q.blue_in, q.green_in, q.red_in} = rgba;
    q.attack_ticks = a;
    q.hold_ticks = h;
    q.release_ticks = r;
    return q;
  endfunction

  function automatic fem_req_t make_tick(logic [15:0] f);
    fem_req_t     q;
    logic [127:0] rnd;
    rnd = {$urandom, $urandom, $urandom, $urandom};
    q = rnd[$bits(fem_req_t)-1:0];
    q.cmd = CMD_TICK;
    q.frame_ticks = f;
    return q;
  endfunction

  // one request: optional random idle gap, then hold start until taken;
  // start is left high so the next request follows with no gap
  task automatic send_request(fem_req_t q, bit may_idle);
    while (may_idle && $urandom_range(0, 99) < 16) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_req <= q;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin
    logic [15:0] frame;
    start = 1'b0;
    in_req = '0;
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: tick with nothing live, colour extremes, zero durations
    send_request(make_tick(16'd0), 0);
    send_request(make_add(32'hFFFFFFFF, 16'd4, 16'd2, 16'd4), 0);
    send_request(make_add(32'h00000000, 16'd0, 16'd0, 16'd0), 0);
    send_request(make_add(32'hFF00FF00, 16'd0, 16'd3, 16'd5), 0);
    send_request(make_add(32'h00FF00FF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 0);
    // zero total duration frees on its first tick even with zero frame
    send_request(make_tick(16'd0), 0);
    send_request(make_add(32'h80402010, 16'd3, 16'd0, 16'd3), 0);
    send_request(make_add(32'hFFFFFFFF, 16'd1, 16'd1, 16'd1), 0);
    send_request(make_add(32'h12345678, 16'd8, 16'd8, 16'd8), 0);
    send_request(make_add(32'hABCDEF01, 16'd2, 16'd0, 16'd9), 0);
    send_request(make_add(32'h7F7F7F7F, 16'd5, 16'd5, 16'd0), 0);
    // every slot busy: dropped add
    send_request(make_add(32'hFFFFFFFF, 16'd1, 16'd1, 16'd1), 0);
    send_request(make_tick(16'd1), 0);
    send_request(make_tick(16'd2), 0);
    send_request(make_tick(16'd3), 0);
    send_request(make_tick(16'd5), 0);
    send_request(make_tick(16'hFFFF), 0);
    send_request(make_tick(16'hFFFF), 0);
    send_request(make_tick(16'hFFFF), 0);
    send_request(make_tick(16'hFFFF), 0);

    // random: mostly short flashes with small frames; a clean stretch first
    for (int k = 0; k < 650; k++) begin
      if (k == 300) begin
        // hold off until the block has drained
        start <= 1'b0;
        @(posedge clk);
        while (pending_mixes != 0) @(posedge clk);
      end
      if ($urandom_range(0, 1)) begin
        send_request(make_add($urandom, pick_dur(), pick_dur(), pick_dur()),
                     k > 120);
      end else begin
        frame = ($urandom_range(0, 15) == 0) ? 16'($urandom)
                                             : 16'($urandom_range(0, 6));
        send_request(make_tick(frame), k > 120);
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending_mixes != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
